[rtl/fpr_pkg.sv]
`timescale 1ns / 1ps
package fpr_pkg;

  // Frame marker bytes
  localparam logic [7:0] SYNC_BYTE    = 8'hCD;
  localparam logic [7:0] TYPE_WRITE   = 8'hAB;
  localparam logic [7:0] TYPE_END     = 8'hAE;
  localparam logic [7:0] TYPE_UPGRADE = 8'hA5;

  // CRC-16/UMTS: polynomial 0x8005, initial value zero, no reflection
  localparam logic [15:0] CRC_POLY = 16'h8005;
  localparam logic [15:0] CRC_INIT = 16'h0000;

  localparam int unsigned MAX_PAYLOAD = 1024;
  localparam int unsigned RESV_BYTES  = 4;

  // Configuration register indexes
  localparam logic [1:0] CFG_IDX_WRITE   = 2'd0;
  localparam logic [1:0] CFG_IDX_END     = 2'd1;
  localparam logic [1:0] CFG_IDX_UPGRADE = 2'd2;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2,
    KIND_LONG = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_END     = 2'd1,
    OP_UPGRADE = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [15:0] write_code;
    logic [15:0] end_code;
    logic [15:0] upgrade_code;
  } cfg_codes_t;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [7:0]  data_byte;
    cmd_e        command;
    logic [15:0] frame_length;
    logic        last;
  } result_t;

  // One byte through the CRC register, MSB first
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

[rtl/fpr_parser.sv]
`timescale 1ns / 1ps
module fpr_parser import fpr_pkg::*; #(
  parameter int unsigned MaxPayload = MAX_PAYLOAD
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  cfg_codes_t codes_i,
  output result_t    result_o
);

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_TYPE    = 3'd1;
  localparam logic [2:0] PH_LEN_LO  = 3'd2;
  localparam logic [2:0] PH_LEN_HI  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_RESV    = 3'd5;
  localparam logic [2:0] PH_CRC_LO  = 3'd6;
  localparam logic [2:0] PH_CRC_HI  = 3'd7;

  // Counter covers the payload length and the reserved-byte count
  localparam int unsigned CntW = ($clog2(MaxPayload + 1) > 3) ?
                                 $clog2(MaxPayload + 1) : 3;

  logic [2:0]      phase_q, phase_d;
  cmd_e            frame_type_q, frame_type_d;
  logic [15:0]     length_q, length_d;
  logic [CntW-1:0] count_q, count_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      crc_lo_q, crc_lo_d;
  logic [CntW-1:0] cnt_inc;
  logic [15:0]     code;

  assign cnt_inc = count_q + 1'b1;

  always_comb begin
    phase_d      = phase_q;
    frame_type_d = frame_type_q;
    length_d     = length_q;
    count_d      = count_q;
    crc_d        = crc_q;
    crc_lo_d     = crc_lo_q;
    code         = codes_i.write_code;
    result_o     = '0;
    case (phase_q)
      PH_HUNT: begin
        if (byte_i == SYNC_BYTE) phase_d = PH_TYPE;
      end
      PH_TYPE: begin
        if (byte_i == TYPE_WRITE || byte_i == TYPE_END || byte_i == TYPE_UPGRADE) begin
          if (byte_i == TYPE_END) begin
            frame_type_d = OP_END;
            code         = codes_i.end_code;
          end else if (byte_i == TYPE_UPGRADE) begin
            frame_type_d = OP_UPGRADE;
            code         = codes_i.upgrade_code;
          end else begin
            frame_type_d = OP_WRITE;
          end
          crc_d    = crc16_byte(crc16_byte(CRC_INIT, code[7:0]), code[15:8]);
          length_d = '0;
          count_d  = '0;
          phase_d  = PH_LEN_LO;
        end else begin
          // re-examine a bad type byte as a sync byte
          phase_d = (byte_i == SYNC_BYTE) ? PH_TYPE : PH_HUNT;
        end
      end
      PH_LEN_LO: begin
        length_d = {8'h00, byte_i};
        crc_d    = crc16_byte(crc_q, byte_i);
        phase_d  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_d = {byte_i, length_q[7:0]};
        crc_d    = crc16_byte(crc_q, byte_i);
        count_d  = '0;
        if (length_d > 16'(MaxPayload)) begin
          result_o.valid = 1'b1;
          result_o.kind  = KIND_LONG;
          result_o.last  = 1'b1;
          phase_d        = PH_HUNT;
        end else begin
          phase_d = (length_d == '0) ? PH_RESV : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        crc_d              = crc16_byte(crc_q, byte_i);
        result_o.valid     = 1'b1;
        result_o.kind      = KIND_DATA;
        result_o.data_byte = byte_i;
        count_d            = cnt_inc;
        if (16'(cnt_inc) >= length_q) begin
          count_d = '0;
          phase_d = PH_RESV;
        end
      end
      PH_RESV: begin
        count_d = cnt_inc;
        if (cnt_inc >= CntW'(RESV_BYTES)) begin
          count_d = '0;
          phase_d = PH_CRC_LO;
        end
      end
      PH_CRC_LO: begin
        crc_lo_d = byte_i;
        phase_d  = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        result_o.valid = 1'b1;
        result_o.kind  = ({byte_i, crc_lo_q} == crc_q) ? KIND_GOOD : KIND_BAD;
        result_o.last  = 1'b1;
        phase_d        = PH_HUNT;
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
    result_o.command      = frame_type_q;
    result_o.frame_length = length_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      frame_type_q <= OP_WRITE;
      length_q     <= '0;
      count_q      <= '0;
      crc_q        <= '0;
      crc_lo_q     <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      frame_type_q <= frame_type_d;
      length_q     <= length_d;
      count_q      <= count_d;
      crc_q        <= crc_d;
      crc_lo_q     <= crc_lo_d;
    end
  end

endmodule

[rtl/framed_packet_receiver_crc16.sv]
`timescale 1ns / 1ps
// Framed packet receiver with CRC-16/UMTS check. Received bytes enter one per
// transfer; the block hunts for sync byte 0xCD and a type byte (0xAB write,
// 0xAE end, 0xA5 upgrade), then reads a little-endian length, the payload,
// four reserved bytes and a little-endian CRC. Each payload byte leaves as a
// result of kind 0; the frame is closed by one status result with last set:
// kind 1 frame good, kind 2 CRC mismatch, kind 3 length above MaxPayload
// (1024 by default; the block then hunts for sync again). The CRC covers the
// configured command word, the length and the payload. Throughput is one byte
// per clock cycle, sustained, with both sides free to stall. Each byte is first
// held in the input register; once the output register is free or draining,
// the frame state machine and its 8-bit CRC XOR network load any result that
// it yields into the output register. Write the command word registers only
// while no frame is in flight; a frame samples its word when its type byte is
// processed.
module framed_packet_receiver_crc16 import fpr_pkg::*; #(
  parameter int unsigned MaxPayload = MAX_PAYLOAD
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // received bytes
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [1:0]  command_o,
  output logic [15:0] frame_length_o,
  output logic        last_o,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       advance;
  cfg_codes_t codes_q;
  result_t    result;
  result_t    out_q;

  // Process the held byte whenever the output register is free or draining
  assign advance    = in_valid_q && (!out_q.valid || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // Command word registers; an index beyond the list is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q.write_code   <= 16'd0;
      codes_q.end_code     <= 16'd1;
      codes_q.upgrade_code <= 16'd2;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IDX_WRITE:   codes_q.write_code   <= cfg_data_i;
        CFG_IDX_END:     codes_q.end_code     <= cfg_data_i;
        CFG_IDX_UPGRADE: codes_q.upgrade_code <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  fpr_parser #(
    .MaxPayload (MaxPayload)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .codes_i  (codes_q),
    .result_o (result)
  );

  // Output register: load a new result, or clear once the transfer is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (advance && result.valid) begin
      out_q <= result;
    end else if (out_ready_i) begin
      out_q.valid <= 1'b0;
    end
  end

  assign out_valid_o    = out_q.valid;
  assign kind_o         = out_q.kind;
  assign data_byte_o    = out_q.data_byte;
  assign command_o      = out_q.command;
  assign frame_length_o = out_q.frame_length;
  assign last_o         = out_q.last;

endmodule
